// ===== design/vtm4_pkg.sv =====
// ----------------------------------------------------------------------------
// vtm4_pkg
// shared constants for the 4x4 vertex transform core: register map,
// stream field layout and sideband bit positions
// ----------------------------------------------------------------------------
`default_nettype none

package vtm4_pkg;

    // configuration register map
    localparam int unsigned NUM_REGS      = 8;
    localparam int unsigned CFG_IDX_BITS  = 8;
    localparam int unsigned CFG_DATA_BITS = 64;
    localparam int unsigned HALF_BITS     = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_COL0_ROWS01 = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COL0_ROWS23 = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COL1_ROWS01 = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COL1_ROWS23 = 8'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_COL2_ROWS01 = 8'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_COL2_ROWS23 = 8'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_COL3_ROWS01 = 8'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_COL3_ROWS23 = 8'd7;

    // stream field layout
    localparam int unsigned FIELD_BITS = 32;
    localparam int unsigned DATA_BITS  = 3 * FIELD_BITS;
    localparam int unsigned USER_BITS  = 2;
    localparam int unsigned USER_WZERO = 0;
    localparam int unsigned USER_CLIP  = 1;

endpackage

`default_nettype wire

// ===== design/vertex_transform_mat4_core.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_mat4_core
// homogeneous point transform by a column-major 4x4 matrix with perspective
// divide, signed fixed point, saturated results
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  s_      | in        | s_tvalid / s_tready    | s_tdata: in_x, in_y, in_z
//  m_      | out       | m_tvalid / m_tready    | m_tdata: out_x, out_y, out_z
//          |           |                        | m_tuser: w_was_zero, clipped
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  one point per cycle sustained while m_tready does not stall the pipeline;
//  the restoring divider resolves one quotient bit per pipeline stage
//  stages: multiply, row sum, magnitude, range check, WORD_BITS divide, output
//  reset (aresetn low) clears all valid bits and loads the identity matrix
//  a stall on m_tready freezes every stage at once; nothing is lost or repeated
//  cfg_ready is always high; writes beyond the eight registers are dropped
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_mat4_core #(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned WORD_BITS = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input points
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [vtm4_pkg::DATA_BITS-1:0]       s_tdata,  // in_x, in_y, in_z
    // results
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [vtm4_pkg::DATA_BITS-1:0]            m_tdata,  // out_x, out_y, out_z
    output logic [vtm4_pkg::USER_BITS-1:0]            m_tuser,  // w_was_zero, clipped
    // configuration writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [vtm4_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [vtm4_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int unsigned W  = WORD_BITS;
    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned SW = 2 * W + 2;     // exact row sum
    localparam int unsigned RW = 3 * W + 2;     // divider remainder
    localparam int unsigned FB = vtm4_pkg::FIELD_BITS;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [vtm4_pkg::CFG_DATA_BITS-1:0] cfg_reg [vtm4_pkg::NUM_REGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[0] <= vtm4_pkg::CFG_DATA_BITS'(64'd1 << F);
            cfg_reg[1] <= '0;
            cfg_reg[2] <= vtm4_pkg::CFG_DATA_BITS'(64'd1 << (F + 32));
            cfg_reg[3] <= '0;
            cfg_reg[4] <= '0;
            cfg_reg[5] <= vtm4_pkg::CFG_DATA_BITS'(64'd1 << F);
            cfg_reg[6] <= '0;
            cfg_reg[7] <= vtm4_pkg::CFG_DATA_BITS'(64'd1 << (F + 32));
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                vtm4_pkg::REG_COL0_ROWS01: cfg_reg[0] <= cfg_data;
                vtm4_pkg::REG_COL0_ROWS23: cfg_reg[1] <= cfg_data;
                vtm4_pkg::REG_COL1_ROWS01: cfg_reg[2] <= cfg_data;
                vtm4_pkg::REG_COL1_ROWS23: cfg_reg[3] <= cfg_data;
                vtm4_pkg::REG_COL2_ROWS01: cfg_reg[4] <= cfg_data;
                vtm4_pkg::REG_COL2_ROWS23: cfg_reg[5] <= cfg_data;
                vtm4_pkg::REG_COL3_ROWS01: cfg_reg[6] <= cfg_data;
                vtm4_pkg::REG_COL3_ROWS23: cfg_reg[7] <= cfg_data;
                default: ;
            endcase
        end
    end

    // matrix elements, low WORD_BITS of each half
    logic signed [W-1:0] m_el [16];

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            m_el[k] = cfg_reg[k / 2][(k % 2) * vtm4_pkg::HALF_BITS +: W];
        end
    end

    // ------------------------------------------------------------------------
    // global pipeline advance
    // ------------------------------------------------------------------------
    logic adv;
    logic m_valid_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------------
    // stage 1: products
    // ------------------------------------------------------------------------
    logic signed [W-1:0]   in_c [3];
    logic signed [SW-1:0]  prod_next [4][4];
    logic signed [SW-1:0]  prod_reg  [4][4];
    logic signed [2*W-1:0] mul_tmp   [4][3];
    logic signed [W+F-1:0] trans_tmp [4];
    logic                  v1_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            in_c[c] = s_tdata[c * FB +: W];
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                mul_tmp[r][c]   = m_el[r + 4 * c] * in_c[c];
                prod_next[r][c] = SW'(mul_tmp[r][c]);
            end
            trans_tmp[r]    = {m_el[r + 12], F'(0)};
            prod_next[r][3] = SW'(trans_tmp[r]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: row sums
    // ------------------------------------------------------------------------
    logic signed [SW-1:0] sum_reg [4];
    logic                 v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 4; r++) begin
                sum_reg[r] <= prod_reg[r][0] + prod_reg[r][1]
                            + prod_reg[r][2] + prod_reg[r][3];
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: signs, magnitudes, divisor select
    // ------------------------------------------------------------------------
    logic [RW-1:0] num_reg [3];
    logic [SW-1:0] den3_reg;
    logic [2:0]    neg3_reg;
    logic          wz3_reg;
    logic          v3_reg;
    logic          wz_next;
    logic [SW-1:0] mag_next [4];

    always_comb begin
        wz_next = (sum_reg[3] == '0);
        for (int r = 0; r < 4; r++) begin
            mag_next[r] = sum_reg[r][SW-1] ? SW'(-sum_reg[r]) : SW'(sum_reg[r]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wz3_reg  <= wz_next;
            den3_reg <= wz_next ? (SW'(1) << (2 * F)) : mag_next[3];
            for (int r = 0; r < 3; r++) begin
                num_reg[r]  <= RW'({mag_next[r], F'(0)});
                neg3_reg[r] <= sum_reg[r][SW-1] ^ (sum_reg[3][SW-1] & !wz_next);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 4 and divider: index 0 is the range check, then one bit a stage
    // ------------------------------------------------------------------------
    logic [RW-1:0] rem_reg [W+1][3];
    logic [W-1:0]  quo_reg [W+1][3];
    logic [SW-1:0] den_reg [W+1];
    logic [2:0]    neg_reg [W+1];
    logic [2:0]    ovf_reg [W+1];
    logic          wz_reg  [W+1];
    logic          vld_reg [W+1];

    // quotient of 2^WORD_BITS or more always saturates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            den_reg[0] <= den3_reg;
            neg_reg[0] <= neg3_reg;
            wz_reg[0]  <= wz3_reg;
            for (int r = 0; r < 3; r++) begin
                rem_reg[0][r] <= num_reg[r];
                quo_reg[0][r] <= '0;
                ovf_reg[0][r] <= (num_reg[r] >= (RW'(den3_reg) << W));
            end
        end
    end

    for (genvar j = 0; j < W; j++) begin : g_div
        localparam int unsigned SH = W - 1 - j;
        logic [RW-1:0] trial;

        assign trial = RW'(den_reg[j]) << SH;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                den_reg[j+1] <= den_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
                wz_reg[j+1]  <= wz_reg[j];
                for (int r = 0; r < 3; r++) begin
                    if (rem_reg[j][r] >= trial) begin
                        rem_reg[j+1][r] <= rem_reg[j][r] - trial;
                        quo_reg[j+1][r] <= quo_reg[j][r] | (W'(1) << SH);
                    end else begin
                        rem_reg[j+1][r] <= rem_reg[j][r];
                        quo_reg[j+1][r] <= quo_reg[j][r];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // output stage: sign, saturation, packing
    // ------------------------------------------------------------------------
    localparam logic [W-1:0] LIMIT = W'(1) << (W - 1);

    logic [W-1:0]                  res_next  [3];
    logic [2:0]                    clip_next;
    logic [vtm4_pkg::DATA_BITS-1:0] data_next;
    logic [vtm4_pkg::DATA_BITS-1:0] data_reg;
    logic [vtm4_pkg::USER_BITS-1:0] user_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (neg_reg[W][r]) begin
                clip_next[r] = ovf_reg[W][r] || (quo_reg[W][r] > LIMIT);
                res_next[r]  = clip_next[r] ? LIMIT : W'(-quo_reg[W][r]);
            end else begin
                clip_next[r] = ovf_reg[W][r] || (quo_reg[W][r] > LIMIT - W'(1));
                res_next[r]  = clip_next[r] ? (LIMIT - W'(1)) : quo_reg[W][r];
            end
            data_next[r * FB +: FB] = FB'($signed(res_next[r]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg                       <= data_next;
            user_reg[vtm4_pkg::USER_WZERO] <= wz_reg[W];
            user_reg[vtm4_pkg::USER_CLIP]  <= |clip_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // zero w must select a divisor of exactly 1.0 in the product format
    a_wzero_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[0] && wz_reg[0]) |-> (den_reg[0] == (SW'(1) << (2 * F))))
        else $error("zero w did not select unit divisor");

    // divisor never zero inside the divider
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[0] |-> (den_reg[0] != '0))
        else $error("zero divisor entered divider");

    // a stall freezes the last divide stage
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(vld_reg[W]) && $stable(quo_reg[W][0])))
        else $error("divider advanced during stall");

endmodule

`default_nettype wire
